@@ rtl/core/hgd_pkg.sv @@
// ----------------------------------------------------------------------------
// hgd_pkg
// Shared widths, score constants, command and state codes and the result
// record of the hex-grid distance map.
// ----------------------------------------------------------------------------
package hgd_pkg;

   // default largest map side; the store holds its square
   localparam int MAX_SIDE_DEF = 128;

   // fixed field widths of the channels
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 14;
   localparam int SCORE_W = 16;
   localparam int CSR_W   = 8;
   localparam int NBR_N   = 6;
   localparam int SLOT_W  = 3;

   // wide enough for any position and for the square of the largest side
   localparam int CMP_W = 17;

   // store fill value and the ceiling a live score can take
   localparam logic [SCORE_W-1:0] SCORE_KILL = 16'hFFFF;
   localparam logic [SCORE_W-1:0] SCORE_CAP  = 16'hFFFE;

   // neighbor gather slots: the cell itself, then NE, E, SE, SW, W, NW
   localparam logic [SLOT_W-1:0] SLOT_SELF = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_NE   = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_E    = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_SE   = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_SW   = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_W_   = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_NW   = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_READ  = 3'd2,
      CMD_QUERY = 3'd3,
      CMD_RELAX = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_DIVIDE,
      ST_GATHER,
      ST_DELIVER
   } state_type;

   // one result record; nbr[0..5] is NE, E, SE, SW, W, NW
   typedef struct packed {
      logic [SCORE_W-1:0]            score_value;
      logic [NBR_N-1:0][SCORE_W-1:0] nbr;
      logic                          failed;
   } result_type;

endpackage

@@ rtl/core/hgd_ram.sv @@
// ----------------------------------------------------------------------------
// hgd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hgd_ram #(
   parameter int WIDTH = hgd_pkg::SCORE_W,
   parameter int DEPTH = hgd_pkg::MAX_SIDE_DEF * hgd_pkg::MAX_SIDE_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read; read returns the old word on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/hgd_div.sv @@
// ----------------------------------------------------------------------------
// hgd_div
// Restoring divider, one quotient bit per cycle. Splits a cell position into
// row (quotient) and column (remainder) by the map side.
// ----------------------------------------------------------------------------
module hgd_div #(
   parameter int DIVIDEND_W = hgd_pkg::INDEX_W,
   parameter int DIVISOR_W  = $clog2(hgd_pkg::MAX_SIDE_DEF + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(diff) : DIVISOR_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/core/hgd_engine.sv @@
// ----------------------------------------------------------------------------
// hgd_engine
// Command sequencer: clear sweep, single-cell access, neighbor gather and the
// relax passes on the score memory; relax is a read-modify-write.
// ----------------------------------------------------------------------------
module hgd_engine #(
   parameter int MAX_SIDE = hgd_pkg::MAX_SIDE_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [hgd_pkg::CMD_W-1:0]                req_command,
   input  logic [hgd_pkg::INDEX_W-1:0]              req_cell_index,
   input  logic [hgd_pkg::SCORE_W-1:0]              req_new_score,
   // map geometry
   input  logic [$clog2(MAX_SIDE+1)-1:0]            side,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]   side_sq,
   // score memory
   output logic                                     ram_wr_en,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]     ram_wr_addr,
   output logic [hgd_pkg::SCORE_W-1:0]              ram_wr_data,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]     ram_rd_addr,
   input  logic [hgd_pkg::SCORE_W-1:0]              ram_rd_data,
   // row / column divider
   output logic                                     div_start,
   input  logic                                     div_done,
   input  logic [hgd_pkg::INDEX_W-1:0]              div_quotient,
   input  logic [$clog2(MAX_SIDE+1)-1:0]            div_remainder,
   // finished result
   output logic                                     res_valid,
   input  logic                                     res_take,
   output hgd_pkg::result_type                      res
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int SQ_W   = $clog2(DEPTH + 1);
   localparam int RC_W   = $clog2(MAX_SIDE);
   localparam int CW     = SIDE_W + 1;
   localparam int AW1    = ADDR_W + 1;
   localparam int SW     = hgd_pkg::SCORE_W;

   hgd_pkg::state_type         state_ff, state_in;
   logic                       ready_ff, ready_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic [RC_W-1:0]            row_ff, row_in;
   logic [RC_W-1:0]            col_ff, col_in;
   logic [hgd_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic                       relax_ff, relax_in;
   logic [SW-1:0]              pass_ff, pass_in;
   logic                       changed_ff, changed_in;
   logic [SW-1:0]              self_ff, self_in;
   logic [SW-1:0]              nb_ff [hgd_pkg::NBR_N];
   logic [SW-1:0]              nb_in [hgd_pkg::NBR_N];
   hgd_pkg::result_type        res_ff, res_in;

   // geometry of the current cell
   logic                       ind, north, south, east, west, deast, dwest;
   logic [AW1-1:0]             posw, sidew, indw, slot_addw;
   logic [7:0]                 off_vec;
   logic [hgd_pkg::SLOT_W-1:0] recv_slot;
   logic [hgd_pkg::SLOT_W-1:0] nb_idx;
   logic [SW-1:0]              recv_val;

   // relax update
   logic [SW-1:0]              m01, m23, m45, m0123, lo6, lo;
   logic [SW:0]                lo_inc;
   logic                       upd, eligible;

   // request decode
   logic [ADDR_W-1:0]          req_pos;
   logic                       on_map, cmd_known;
   logic                       cell_done, cell_chg, chg_any, last_cell;

   assign req_pos   = ADDR_W'(req_cell_index);
   assign on_map    = hgd_pkg::CMP_W'(req_cell_index) < hgd_pkg::CMP_W'(side_sq);
   assign cmd_known = req_command <= hgd_pkg::CMD_RELAX;

   // neighbor existence and addresses; odd rows sit half a cell east
   always_comb begin
      ind   = row_ff[0];
      north = row_ff != '0;
      south = (CW'(row_ff) + CW'(1)) < CW'(side);
      east  = (CW'(col_ff) + CW'(1)) < CW'(side);
      west  = col_ff != '0;
      deast = !ind || east;
      dwest = ind || west;

      posw  = AW1'(pos_ff);
      sidew = AW1'(side);
      indw  = AW1'(ind);

      off_vec                     = '0;
      off_vec[hgd_pkg::SLOT_NE]   = !(north && deast);
      off_vec[hgd_pkg::SLOT_E]    = !east;
      off_vec[hgd_pkg::SLOT_SE]   = !(south && deast);
      off_vec[hgd_pkg::SLOT_SW]   = !(south && dwest);
      off_vec[hgd_pkg::SLOT_W_]   = !west;
      off_vec[hgd_pkg::SLOT_NW]   = !(north && dwest);

      unique case (slot_ff)
         hgd_pkg::SLOT_NE: slot_addw = posw - sidew + indw;
         hgd_pkg::SLOT_E:  slot_addw = posw + AW1'(1);
         hgd_pkg::SLOT_SE: slot_addw = posw + sidew + indw;
         hgd_pkg::SLOT_SW: slot_addw = posw + sidew + indw - AW1'(1);
         hgd_pkg::SLOT_W_: slot_addw = posw - AW1'(1);
         hgd_pkg::SLOT_NW: slot_addw = posw - sidew + indw - AW1'(1);
         default:          slot_addw = posw;
      endcase

      // data arriving now was addressed one slot earlier
      recv_slot = slot_ff - hgd_pkg::SLOT_W'(1);
      nb_idx    = slot_ff - hgd_pkg::SLOT_E;
      if (off_vec[recv_slot]) begin
         recv_val = relax_ff ? hgd_pkg::SCORE_CAP : hgd_pkg::SCORE_KILL;
      end else begin
         recv_val = ram_rd_data;
      end
   end

   // lowest neighbor over the five held scores and the one arriving now
   always_comb begin
      m01    = (nb_ff[0] < nb_ff[1]) ? nb_ff[0] : nb_ff[1];
      m23    = (nb_ff[2] < nb_ff[3]) ? nb_ff[2] : nb_ff[3];
      m45    = (nb_ff[4] < recv_val) ? nb_ff[4] : recv_val;
      m0123  = (m01 < m23) ? m01 : m23;
      lo6    = (m0123 < m45) ? m0123 : m45;
      lo     = (lo6 < hgd_pkg::SCORE_CAP) ? lo6 : hgd_pkg::SCORE_CAP;
      lo_inc = {1'b0, lo} + (SW+1)'(1);
      upd    = {1'b0, self_ff} > lo_inc;
      eligible = (ram_rd_data <= hgd_pkg::SCORE_CAP) && (ram_rd_data > pass_ff);
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      ready_in    = ready_ff;
      clr_addr_in = clr_addr_ff;
      pos_in      = pos_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      slot_in     = slot_ff;
      relax_in    = relax_ff;
      pass_in     = pass_ff;
      changed_in  = changed_ff;
      self_in     = self_ff;
      nb_in       = nb_ff;
      res_in      = res_ff;

      req_stall   = state_ff != hgd_pkg::ST_IDLE;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = req_new_score;
      ram_rd_addr = ADDR_W'(slot_addw);
      div_start   = 1'b0;
      res_valid   = 1'b0;
      cell_done   = 1'b0;
      cell_chg    = 1'b0;

      unique case (state_ff)
         hgd_pkg::ST_IDLE: begin
            ram_rd_addr = req_pos;
            if (req_valid) begin
               res_in   = '0;
               state_in = hgd_pkg::ST_DELIVER;
               priority if (req_command == hgd_pkg::CMD_CLEAR) begin
                  state_in    = hgd_pkg::ST_CLEAR;
                  clr_addr_in = '0;
               end else if (!cmd_known || !ready_ff) begin
                  res_in.failed = 1'b1;
               end else if (req_command == hgd_pkg::CMD_RELAX) begin
                  // an empty map finishes at once
                  if (side_sq != '0) begin
                     state_in   = hgd_pkg::ST_GATHER;
                     relax_in   = 1'b1;
                     pos_in     = '0;
                     row_in     = '0;
                     col_in     = '0;
                     slot_in    = hgd_pkg::SLOT_SELF;
                     pass_in    = '0;
                     changed_in = 1'b0;
                  end
               end else if (!on_map) begin
                  res_in.failed = 1'b1;
               end else begin
                  unique case (req_command)
                     hgd_pkg::CMD_WRITE: begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_pos;
                     end
                     hgd_pkg::CMD_READ: begin
                        state_in = hgd_pkg::ST_READ;
                     end
                     default: begin
                        div_start = 1'b1;
                        state_in  = hgd_pkg::ST_DIVIDE;
                        pos_in    = req_pos;
                        relax_in  = 1'b0;
                     end
                  endcase
               end
            end
         end

         hgd_pkg::ST_CLEAR: begin
            // sweep the whole store with the fill value
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = hgd_pkg::SCORE_KILL;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               ready_in = 1'b1;
               state_in = hgd_pkg::ST_DELIVER;
            end
         end

         hgd_pkg::ST_READ: begin
            res_in.score_value = ram_rd_data;
            state_in           = hgd_pkg::ST_DELIVER;
         end

         hgd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               row_in   = RC_W'(div_quotient);
               col_in   = RC_W'(div_remainder);
               slot_in  = hgd_pkg::SLOT_SELF;
               state_in = hgd_pkg::ST_GATHER;
            end
         end

         hgd_pkg::ST_GATHER: begin
            slot_in = slot_ff + hgd_pkg::SLOT_W'(1);
            if (slot_ff == hgd_pkg::SLOT_NE) begin
               // own score arrives; skip cells that cannot improve
               self_in = ram_rd_data;
               if (relax_ff && !eligible) begin
                  cell_done = 1'b1;
               end
            end else if (slot_ff == hgd_pkg::SLOT_LAST) begin
               if (relax_ff) begin
                  cell_done = 1'b1;
                  cell_chg  = upd;
                  if (upd) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = SW'(lo_inc);
                  end
               end else begin
                  for (int i = 0; i < hgd_pkg::NBR_N - 1; i++) begin
                     res_in.nbr[i] = nb_ff[i];
                  end
                  res_in.nbr[hgd_pkg::NBR_N-1] = recv_val;
                  state_in = hgd_pkg::ST_DELIVER;
               end
            end else if (slot_ff != hgd_pkg::SLOT_SELF) begin
               nb_in[nb_idx] = recv_val;
            end
         end

         hgd_pkg::ST_DELIVER: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = hgd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hgd_pkg::ST_IDLE;
         end
      endcase

      // advance the relax scan to the next cell, or close the pass
      chg_any   = changed_ff || cell_chg;
      last_cell = SQ_W'(pos_ff) == (side_sq - SQ_W'(1));
      if (cell_done) begin
         slot_in = hgd_pkg::SLOT_SELF;
         if (last_cell) begin
            pos_in     = '0;
            row_in     = '0;
            col_in     = '0;
            changed_in = 1'b0;
            if (chg_any) begin
               pass_in = pass_ff + SW'(1);
            end else begin
               state_in = hgd_pkg::ST_DELIVER;
            end
         end else begin
            pos_in     = pos_ff + ADDR_W'(1);
            changed_in = chg_any;
            if (!east) begin
               col_in = '0;
               row_in = row_ff + RC_W'(1);
            end else begin
               col_in = col_ff + RC_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hgd_pkg::ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
      clr_addr_ff <= clr_addr_in;
      pos_ff      <= pos_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      slot_ff     <= slot_in;
      relax_ff    <= relax_in;
      pass_ff     <= pass_in;
      changed_ff  <= changed_in;
      self_ff     <= self_in;
      nb_ff       <= nb_in;
      res_ff      <= res_in;
   end

   assign res = res_ff;

endmodule

@@ rtl/core/hex_grid_distance_map.sv @@
// ----------------------------------------------------------------------------
// hex_grid_distance_map
// Hex-grid score store with clear, write, read, neighbor query and relax.
// ----------------------------------------------------------------------------
// All scores live in one RAM of MAX_SIDE*MAX_SIDE 16-bit words with one read
// and one write port, and every command works on that one store. A write or
// a refused command goes straight to delivery; a read first captures the RAM
// word. Clear rewrites the whole store, one word a cycle. A neighbor query
// splits the position into row and column with a one-bit-per-cycle divider,
// then fetches the six neighbors one a cycle. Relax walks every cell of the
// map per pass; a cell whose score cannot change is skipped once its own
// score arrives, one that is examined reads its own score plus six neighbors
// and writes back a lower score if it finds one, and relax ends after the
// first pass without a change. The result sits in an output register, so
// the next request is taken while a result still waits to be transferred.
// ----------------------------------------------------------------------------
module hex_grid_distance_map #(
   parameter int MAX_SIDE = hgd_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [hgd_pkg::CSR_W-1:0]     csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hgd_pkg::CMD_W-1:0]     req_command,
   input  logic [hgd_pkg::INDEX_W-1:0]   req_cell_index,
   input  logic [hgd_pkg::SCORE_W-1:0]   req_new_score,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_score_value,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_ne,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_e,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_se,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_sw,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_w,
   output logic [hgd_pkg::SCORE_W-1:0]   rsp_neighbor_nw,
   output logic                          rsp_failed
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int SQ_W   = $clog2(DEPTH + 1);

   logic [SIDE_W-1:0]            side_ff, side_in;
   logic [SQ_W-1:0]              side_sq_ff, side_sq_in;
   logic [hgd_pkg::CSR_W:0]      csr_ext;
   logic [2*SIDE_W-1:0]          sq_full;

   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [hgd_pkg::SCORE_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0]            ram_rd_addr;
   logic [hgd_pkg::SCORE_W-1:0]  ram_rd_data;

   logic                         div_start;
   logic                         div_done;
   logic [hgd_pkg::INDEX_W-1:0]  div_quotient;
   logic [SIDE_W-1:0]            div_remainder;

   logic                         res_valid;
   logic                         res_take;
   hgd_pkg::result_type          res;

   logic                         rsp_valid_ff, rsp_valid_in;
   hgd_pkg::result_type          rsp_data_ff, rsp_data_in;

   // clamp the side to the store and keep its square ready
   always_comb begin
      side_in    = side_ff;
      side_sq_in = side_sq_ff;
      csr_ext    = {1'b0, csr_wr_data};
      if (csr_ext > (hgd_pkg::CSR_W+1)'(MAX_SIDE)) begin
         sq_full = (2*SIDE_W)'(SIDE_W'(MAX_SIDE)) * (2*SIDE_W)'(SIDE_W'(MAX_SIDE));
      end else begin
         sq_full = (2*SIDE_W)'(SIDE_W'(csr_ext)) * (2*SIDE_W)'(SIDE_W'(csr_ext));
      end
      if (csr_wr_en) begin
         if (csr_ext > (hgd_pkg::CSR_W+1)'(MAX_SIDE)) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(csr_ext);
         end
         side_sq_in = SQ_W'(sq_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= SIDE_W'(1);
         side_sq_ff <= SQ_W'(1);
      end else begin
         side_ff    <= side_in;
         side_sq_ff <= side_sq_in;
      end
   end

   hgd_ram #(
      .WIDTH (hgd_pkg::SCORE_W),
      .DEPTH (DEPTH)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hgd_div #(
      .DIVIDEND_W (hgd_pkg::INDEX_W),
      .DIVISOR_W  (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_cell_index),
      .divisor   (side_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   hgd_engine #(
      .MAX_SIDE (MAX_SIDE)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_cell_index (req_cell_index),
      .req_new_score  (req_new_score),
      .side           (side_ff),
      .side_sq        (side_sq_ff),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .div_start      (div_start),
      .div_done       (div_done),
      .div_quotient   (div_quotient),
      .div_remainder  (div_remainder),
      .res_valid      (res_valid),
      .res_take       (res_take),
      .res            (res)
   );

   // output register: load when empty or when its transfer happens now
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score_value = rsp_data_ff.score_value;
   assign rsp_neighbor_ne = rsp_data_ff.nbr[0];
   assign rsp_neighbor_e  = rsp_data_ff.nbr[1];
   assign rsp_neighbor_se = rsp_data_ff.nbr[2];
   assign rsp_neighbor_sw = rsp_data_ff.nbr[3];
   assign rsp_neighbor_w  = rsp_data_ff.nbr[4];
   assign rsp_neighbor_nw = rsp_data_ff.nbr[5];
   assign rsp_failed      = rsp_data_ff.failed;

endmodule
